FILE: rtl/particle_attractor_euler_update_assert.svh
// Assertion macros used by the checker file
`ifndef PARTICLE_ATTRACTOR_EULER_UPDATE_ASSERT_SVH
`define PARTICLE_ATTRACTOR_EULER_UPDATE_ASSERT_SVH

// Antecedent implies consequent in the same cycle, ignored during reset
`define PAE_ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed: same-cycle check");

// Antecedent implies consequent in the next cycle; pass 1'b1 as rst_n to check through reset
`define PAE_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/pae_pkg.sv
package pae_pkg;

    localparam int MAX_ATTR  = 4;
    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [31:0] q_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXT_FORCE_X = 3'd0,
        REG_EXT_FORCE_Y = 3'd1,
        REG_EXT_FORCE_Z = 3'd2,
        REG_ROT_AXIS_X  = 3'd3,
        REG_ROT_AXIS_Y  = 3'd4,
        REG_ROT_AXIS_Z  = 3'd5,
        REG_INV_MASS    = 3'd6,
        REG_ATTR_COUNT  = 3'd7
    } cfg_reg_t;

    localparam q_t            EXT_FORCE_Y_RST = -32'sd642253;
    localparam q_t            ROT_AXIS_Y_RST  = 32'sd65536;
    localparam logic [30:0]   INV_MASS_RST    = 31'd131072;

    typedef struct packed {
        logic        mode;
        q_t          pos_x;
        q_t          pos_y;
        q_t          pos_z;
        q_t          vel_x;
        q_t          vel_y;
        q_t          vel_z;
        logic [19:0] time_step;
        logic [1:0]  slot;
        q_t          power;
    } in_t;

    typedef struct packed {
        q_t new_pos_x;
        q_t new_pos_y;
        q_t new_pos_z;
        q_t new_vel_x;
        q_t new_vel_y;
        q_t new_vel_z;
    } out_t;

    localparam logic signed [64:0] SAT_MAX = 65'sh0_7fff_ffff;
    localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

    function automatic q_t sat32(input logic signed [64:0] v);
        q_t r;
        if (v > SAT_MAX) begin
            r = 32'sh7fff_ffff;
        end else if (v < SAT_MIN) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat32(65'(a) + 65'(b));
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat32(65'(a) - 65'(b));
    endfunction

    // exact product, floor toward minus infinity, then saturate
    function automatic q_t qmul(input logic signed [32:0] a, input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [65:0] s;
        p = a * b;
        s = p >>> FRAC_BITS;
        return sat32(s[64:0]);
    endfunction

endpackage

FILE: rtl/particle_attractor_euler_update.sv
// Semi-implicit Euler particle update in Q16.16 with up to four orbit
// attractors. A result appears on m_data once its update item has passed
// through 13 register stages, the first loaded at the accepting edge; one
// item enters per cycle, with all four attractor lanes unrolled and a shared
// stall: when the output register holds an item not yet taken, the whole
// pipeline and the input hold. Attractor-write items (mode 1) update the slot
// at acceptance and give no result; later items see it.
module particle_attractor_euler_update (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pae_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pae_pkg::out_t                 m_data
);
    import pae_pkg::*;

    localparam int NST = 13;

    q_t          ext_reg [3];
    q_t          rot_reg [3];
    logic [30:0] inv_mass_reg;
    logic [2:0]  count_reg;

    q_t centre_reg [MAX_ATTR][3];
    q_t str_reg    [MAX_ATTR];

    logic [NST:1] vld_reg;
    logic         en;
    logic         acc;
    q_t           pin [3];
    q_t           vin [3];

    q_t          p_pipe_reg  [1:12][3];
    q_t          v_pipe_reg  [1:10][3];
    logic [19:0] dt_pipe_reg [1:11];

    q_t   d1_reg  [MAX_ATTR][3];
    q_t   d2_reg  [MAX_ATTR][3];
    q_t   d3_reg  [MAX_ATTR][3];
    q_t   w1_reg  [MAX_ATTR];
    q_t   w2_reg  [MAX_ATTR];
    q_t   w3_reg  [MAX_ATTR];
    q_t   w4_reg  [MAX_ATTR];
    logic msk1_reg [MAX_ATTR];
    logic msk2_reg [MAX_ATTR];
    logic msk3_reg [MAX_ATTR];
    logic msk4_reg [MAX_ATTR];
    q_t   pra2_reg [MAX_ATTR][3];
    q_t   prb2_reg [MAX_ATTR][3];
    q_t   c3_reg   [MAX_ATTR][3];
    q_t   e4_reg   [MAX_ATTR][3];
    q_t   m5_reg   [MAX_ATTR][3];
    q_t   m6_reg   [MAX_ATTR][3];
    q_t   f6_reg   [3];
    q_t   f7_reg   [3];
    q_t   f8_reg   [3];
    q_t   a9_reg   [3];
    q_t   t10_reg  [3];
    q_t   v11_reg  [3];
    q_t   v12_reg  [3];
    q_t   u12_reg  [3];
    q_t   np13_reg [3];
    q_t   v13_reg  [3];

    assign en      = !vld_reg[NST] || m_ready;
    assign s_ready = en;
    assign acc     = s_valid && en;
    assign m_valid = vld_reg[NST];

    assign pin[0] = s_data.pos_x;
    assign pin[1] = s_data.pos_y;
    assign pin[2] = s_data.pos_z;
    assign vin[0] = s_data.vel_x;
    assign vin[1] = s_data.vel_y;
    assign vin[2] = s_data.vel_z;

    assign m_data.new_pos_x = np13_reg[0];
    assign m_data.new_pos_y = np13_reg[1];
    assign m_data.new_pos_z = np13_reg[2];
    assign m_data.new_vel_x = v13_reg[0];
    assign m_data.new_vel_y = v13_reg[1];
    assign m_data.new_vel_z = v13_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg[0]   <= '0;
            ext_reg[1]   <= EXT_FORCE_Y_RST;
            ext_reg[2]   <= '0;
            rot_reg[0]   <= '0;
            rot_reg[1]   <= ROT_AXIS_Y_RST;
            rot_reg[2]   <= '0;
            inv_mass_reg <= INV_MASS_RST;
            count_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_EXT_FORCE_X: ext_reg[0]   <= cfg_wdata;
                REG_EXT_FORCE_Y: ext_reg[1]   <= cfg_wdata;
                REG_EXT_FORCE_Z: ext_reg[2]   <= cfg_wdata;
                REG_ROT_AXIS_X:  rot_reg[0]   <= cfg_wdata;
                REG_ROT_AXIS_Y:  rot_reg[1]   <= cfg_wdata;
                REG_ROT_AXIS_Z:  rot_reg[2]   <= cfg_wdata;
                REG_INV_MASS:    inv_mass_reg <= cfg_wdata[30:0];
                REG_ATTR_COUNT:  count_reg    <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // attractor slot write at acceptance
    always_ff @(posedge aclk) begin
        if (acc && s_data.mode && (int'(s_data.slot) < MAX_ATTR)) begin
            for (int k = 0; k < 3; k++) begin
                centre_reg[s_data.slot][k] <= pin[k];
            end
            str_reg[s_data.slot] <= s_data.power;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-1:1], acc && !s_data.mode};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                p_pipe_reg[1][k] <= pin[k];
                v_pipe_reg[1][k] <= vin[k];
                for (int s = 2; s <= 12; s++) begin
                    p_pipe_reg[s][k] <= p_pipe_reg[s-1][k];
                end
                for (int s = 2; s <= 10; s++) begin
                    v_pipe_reg[s][k] <= v_pipe_reg[s-1][k];
                end
            end
            dt_pipe_reg[1] <= s_data.time_step;
            for (int s = 2; s <= 11; s++) begin
                dt_pipe_reg[s] <= dt_pipe_reg[s-1];
            end
        end
    end

    // attractor lanes: offset, axis products, cross, minus offset, times power
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < MAX_ATTR; i++) begin
                w1_reg[i]   <= str_reg[i];
                msk1_reg[i] <= (i < int'(count_reg));
                w2_reg[i]   <= w1_reg[i];
                w3_reg[i]   <= w2_reg[i];
                w4_reg[i]   <= w3_reg[i];
                msk2_reg[i] <= msk1_reg[i];
                msk3_reg[i] <= msk2_reg[i];
                msk4_reg[i] <= msk3_reg[i];
                for (int k = 0; k < 3; k++) begin
                    int j;
                    int l;
                    j = (k == 2) ? 0 : k + 1;
                    l = (k == 0) ? 2 : k - 1;
                    d1_reg[i][k]   <= qsub(pin[k], centre_reg[i][k]);
                    pra2_reg[i][k] <= qmul(33'(d1_reg[i][j]), 33'(rot_reg[l]));
                    prb2_reg[i][k] <= qmul(33'(d1_reg[i][l]), 33'(rot_reg[j]));
                    d2_reg[i][k]   <= d1_reg[i][k];
                    c3_reg[i][k]   <= qsub(pra2_reg[i][k], prb2_reg[i][k]);
                    d3_reg[i][k]   <= d2_reg[i][k];
                    e4_reg[i][k]   <= qsub(c3_reg[i][k], d3_reg[i][k]);
                    m5_reg[i][k]   <= msk4_reg[i]
                                      ? qmul(33'(e4_reg[i][k]), 33'(w4_reg[i])) : '0;
                    m6_reg[i][k]   <= m5_reg[i][k];
                end
            end
        end
    end

    // accumulate slots in order, then external force and the Euler step
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                f6_reg[k]   <= qadd(m5_reg[0][k], m5_reg[1][k]);
                f7_reg[k]   <= qadd(qadd(f6_reg[k], m6_reg[2][k]), m6_reg[3][k]);
                f8_reg[k]   <= qadd(f7_reg[k], ext_reg[k]);
                a9_reg[k]   <= qmul(33'(f8_reg[k]), $signed({2'b00, inv_mass_reg}));
                t10_reg[k]  <= qmul(33'(a9_reg[k]), $signed({13'b0, dt_pipe_reg[9]}));
                v11_reg[k]  <= qadd(v_pipe_reg[10][k], t10_reg[k]);
                u12_reg[k]  <= qmul(33'(v11_reg[k]), $signed({13'b0, dt_pipe_reg[11]}));
                v12_reg[k]  <= v11_reg[k];
                np13_reg[k] <= qadd(p_pipe_reg[12][k], u12_reg[k]);
                v13_reg[k]  <= v12_reg[k];
            end
        end
    end

endmodule

FILE: rtl/pae_checker.sv
`include "particle_attractor_euler_update_assert.svh"

module pae_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input pae_pkg::out_t m_data
);
    import pae_pkg::*;

    `PAE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `PAE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `PAE_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)
    `PAE_ASSERT_SAME(a_ready_flow, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))

endmodule

bind particle_attractor_euler_update pae_checker u_pae_checker (.*);

FILE: tb/particle_attractor_euler_update_check.sv
`timescale 1ns / 100ps

package pae_tb_pkg;
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SLOT   = 1'b1;
endpackage

module particle_attractor_euler_update_check (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  pae_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  pae_pkg::out_t  m_data,
    output int             failures,
    output int             pending,
    output int             results_seen,
    output int             updates_seen,
    output int             slot_writes_seen
);
    import pae_pkg::*;
    import pae_tb_pkg::*;

    longint ext_f[3];
    longint axis[3];
    longint mass_inv;
    int     slots_in_use;
    longint ctr_x[MAX_ATTR], ctr_y[MAX_ATTR], ctr_z[MAX_ATTR], strength[MAX_ATTR];
    out_t   motion_q[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fxadd(longint a, longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint fxsub(longint a, longint b);
        return clamp32(a - b);
    endfunction

    // floor after dropping the fraction bits
    function automatic longint fxmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic out_t advance_particle(in_t d);
        longint px, py, pz, dx, dy, dz, cx, cy, cz, fx, fy, fz, dt, vx, vy, vz;
        int     n;
        out_t   r;
        px = longint'(d.pos_x); py = longint'(d.pos_y); pz = longint'(d.pos_z);
        fx = 0; fy = 0; fz = 0;
        n = (slots_in_use > MAX_ATTR) ? MAX_ATTR : slots_in_use;
        for (int i = 0; i < n; i++) begin
            dx = fxsub(px, ctr_x[i]);
            dy = fxsub(py, ctr_y[i]);
            dz = fxsub(pz, ctr_z[i]);
            cx = fxsub(fxmul(dy, axis[2]), fxmul(dz, axis[1]));
            cy = fxsub(fxmul(dz, axis[0]), fxmul(dx, axis[2]));
            cz = fxsub(fxmul(dx, axis[1]), fxmul(dy, axis[0]));
            fx = fxadd(fx, fxmul(fxsub(cx, dx), strength[i]));
            fy = fxadd(fy, fxmul(fxsub(cy, dy), strength[i]));
            fz = fxadd(fz, fxmul(fxsub(cz, dz), strength[i]));
        end
        fx = fxadd(fx, ext_f[0]);
        fy = fxadd(fy, ext_f[1]);
        fz = fxadd(fz, ext_f[2]);
        dt = longint'(d.time_step);
        vx = fxadd(longint'(d.vel_x), fxmul(fxmul(fx, mass_inv), dt));
        vy = fxadd(longint'(d.vel_y), fxmul(fxmul(fy, mass_inv), dt));
        vz = fxadd(longint'(d.vel_z), fxmul(fxmul(fz, mass_inv), dt));
        r.new_pos_x = q_t'(fxadd(px, fxmul(vx, dt)));
        r.new_pos_y = q_t'(fxadd(py, fxmul(vy, dt)));
        r.new_pos_z = q_t'(fxadd(pz, fxmul(vz, dt)));
        r.new_vel_x = q_t'(vx);
        r.new_vel_y = q_t'(vy);
        r.new_vel_z = q_t'(vz);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t   want;
        q_t     e[6], a[6];
        string  nm[6];
        if (!aresetn) begin
            ext_f[0] = 0; ext_f[1] = longint'(EXT_FORCE_Y_RST); ext_f[2] = 0;
            axis[0] = 0; axis[1] = longint'(ROT_AXIS_Y_RST); axis[2] = 0;
            mass_inv = longint'(INV_MASS_RST);
            slots_in_use = 0;
            for (int i = 0; i < MAX_ATTR; i++) begin
                ctr_x[i] = 0; ctr_y[i] = 0; ctr_z[i] = 0; strength[i] = 0;
            end
            motion_q.delete();
            failures = 0; results_seen = 0; updates_seen = 0; slot_writes_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_EXT_FORCE_X: ext_f[0] = longint'(q_t'(cfg_wdata));
                    REG_EXT_FORCE_Y: ext_f[1] = longint'(q_t'(cfg_wdata));
                    REG_EXT_FORCE_Z: ext_f[2] = longint'(q_t'(cfg_wdata));
                    REG_ROT_AXIS_X:  axis[0] = longint'(q_t'(cfg_wdata));
                    REG_ROT_AXIS_Y:  axis[1] = longint'(q_t'(cfg_wdata));
                    REG_ROT_AXIS_Z:  axis[2] = longint'(q_t'(cfg_wdata));
                    REG_INV_MASS:    mass_inv = longint'(cfg_wdata[30:0]);
                    REG_ATTR_COUNT:  slots_in_use = int'(cfg_wdata[2:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (motion_q.size() == 0) begin
                    $error("result arrived with nothing expected");
                    failures++;
                end else begin
                    want = motion_q.pop_front();
                    e = '{want.new_pos_x, want.new_pos_y, want.new_pos_z,
                          want.new_vel_x, want.new_vel_y, want.new_vel_z};
                    a = '{m_data.new_pos_x, m_data.new_pos_y, m_data.new_pos_z,
                          m_data.new_vel_x, m_data.new_vel_y, m_data.new_vel_z};
                    nm = '{"new_pos_x", "new_pos_y", "new_pos_z",
                           "new_vel_x", "new_vel_y", "new_vel_z"};
                    for (int k = 0; k < 6; k++) begin
                        if (e[k] !== a[k]) begin
                            $error("%s: expected %0d, got %0d", nm[k], e[k], a[k]);
                            failures++;
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_SLOT) begin
                    slot_writes_seen++;
                    if (int'(s_data.slot) < MAX_ATTR) begin
                        ctr_x[s_data.slot] = longint'(s_data.pos_x);
                        ctr_y[s_data.slot] = longint'(s_data.pos_y);
                        ctr_z[s_data.slot] = longint'(s_data.pos_z);
                        strength[s_data.slot] = longint'(s_data.power);
                    end
                end else begin
                    updates_seen++;
                    motion_q = {motion_q, advance_particle(s_data)};
                end
            end
        end
        pending = motion_q.size();
    end
endmodule

FILE: tb/particle_attractor_euler_update_test.sv
`timescale 1ns / 100ps

module particle_attractor_euler_update_test;
    import pae_pkg::*;
    import pae_tb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    int          failures, pending, results_seen, updates_seen, slot_writes_seen;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;

    always #2 aclk = ~aclk;

    particle_attractor_euler_update dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    particle_attractor_euler_update_check checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .failures(failures), .pending(pending), .results_seen(results_seen),
        .updates_seen(updates_seen), .slot_writes_seen(slot_writes_seen)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (long_hold_req) begin
            hold_left = 300;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL particle_attractor_euler_update");
        $finish;
    end

    function automatic q_t pick_q();
        case ($urandom_range(5))
            0: return 32'sh7fff_ffff;
            1: return -32'sh8000_0000;
            2: return q_t'($urandom);
            3: return q_t'($urandom);
            default: return q_t'($urandom_range(1 << 20)) - q_t'(1 << 19);
        endcase
    endfunction

    function automatic in_t random_item(bit slot_write);
        in_t d;
        d.mode = slot_write ? MODE_SLOT : MODE_UPDATE;
        d.pos_x = pick_q(); d.pos_y = pick_q(); d.pos_z = pick_q();
        d.vel_x = pick_q(); d.vel_y = pick_q(); d.vel_z = pick_q();
        d.time_step = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(4096));
        d.slot = 2'($urandom);
        d.power = pick_q();
        return d;
    endfunction

    task automatic send_item(in_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= d;
        forever begin
            #1;
            if (s_ready) begin
                @(posedge aclk);
                break;
            end
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // drain, then cover the pipeline depth for trailing slot writes
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_edge(q_t p, q_t v, logic [19:0] dt);
        in_t d;
        d = '{MODE_UPDATE, p, -p, p, v, v, -v, dt, 2'd3, -32'sd1};
        send_item(d);
    endtask

    initial begin
        in_t        d;
        cfg_reg_t   r;
        logic [31:0] v;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, extremes of position, velocity and step
        send_edge(32'sh7fff_ffff, 32'sh7fff_ffff, 20'hfffff);
        send_edge(-32'sh8000_0000, -32'sh8000_0000, 20'hfffff);
        send_edge(32'sh0, 32'sh0, 20'h0);
        send_edge(32'sh0001_0000, -32'sh8000_0000, 20'h10000);
        send_edge(32'sh7fff_ffff, 32'sh0, 20'h0);
        // load every slot before any is used
        for (int s = 0; s < MAX_ATTR; s++) begin
            d = random_item(1'b1);
            d.slot = 2'(s);
            d.power = (s == 0) ? 32'sh7fff_ffff : (s == 1) ? -32'sh8000_0000 : d.power;
            send_item(d);
        end
        wait_idle();
        write_reg(REG_ATTR_COUNT, 32'd4);
        write_reg(REG_ROT_AXIS_X, 32'h8000_0000);
        write_reg(REG_ROT_AXIS_Z, 32'h7fff_ffff);
        write_reg(REG_INV_MASS, 32'h7fff_ffff);
        send_edge(32'sh7fff_ffff, 32'sh1234, 20'hfffff);
        send_edge(-32'sh8000_0000, 32'sh1234, 20'h00100);
        for (int k = 0; k < 4; k++) send_item(random_item(1'b0));
        wait_idle();
        // count above capacity acts as full
        write_reg(REG_ATTR_COUNT, 32'd7);
        write_reg(REG_EXT_FORCE_X, 32'h7fff_ffff);
        write_reg(REG_EXT_FORCE_Z, 32'h8000_0000);
        write_reg(REG_INV_MASS, 32'h0);
        for (int k = 0; k < 4; k++) send_item(random_item(1'b0));
        wait_idle();

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 11 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 11 : 0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r = cfg_reg_t'(k);
                v = (r == REG_ATTR_COUNT) ? 32'($urandom_range(7)) :
                    (ph == 0 && r == REG_INV_MASS) ? 32'h7fff_ffff :
                    (ph == 1) ? 32'h8000_0000 >> ($urandom_range(1) * 15) :
                    $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1 << 18));
                write_reg(r, v);
            end
            for (int k = 0; k < 325; k++) begin
                if (ph == 0 && k == 100) long_hold_req = 1'b1;
                send_item(random_item($urandom_range(99) < 12));
            end
            wait_idle();
        end

        $display("covered %0d particle updates and %0d slot writes; %0d results checked",
                 updates_seen, slot_writes_seen, results_seen);
        $display("under four idling mixes, a long output hold-off and eight config settings");
        if (failures == 0) begin
            $display("PASS particle_attractor_euler_update");
        end else begin
            $display("FAIL particle_attractor_euler_update");
        end
        $finish;
    end
endmodule

FILE: particle_attractor_euler_update.f
+incdir+rtl
rtl/pae_pkg.sv
rtl/particle_attractor_euler_update.sv
rtl/pae_checker.sv
tb/particle_attractor_euler_update_check.sv
tb/particle_attractor_euler_update_test.sv
